[sv/bdd_pkg.sv]
// shared types and codes for the bounded deque with delete
package bdd_pkg;

    localparam int OP_W     = 3;
    localparam int VALUE_W  = 32;
    localparam int OCC_W    = 7;
    localparam int STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd1;
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
    localparam logic [OP_W-1:0] OP_DELETE     = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

    // read position select
    localparam logic [1:0] RD_BACK  = 2'd0;
    localparam logic [1:0] RD_FRONT = 2'd1;
    localparam logic [1:0] RD_NEXT  = 2'd2;

    // write position select
    localparam logic [1:0] WR_BACK  = 2'd0;
    localparam logic [1:0] WR_FRONT = 2'd1;
    localparam logic [1:0] WR_SHIFT = 2'd2;

    typedef struct packed {
        logic                in_load;
        logic [1:0]          rd_sel;
        logic                wr_en;
        logic [1:0]          wr_sel;
        logic                head_inc;
        logic                head_dec;
        logic                cnt_inc;
        logic                cnt_dec;
        logic                idx_clear;
        logic                idx_inc;
        logic                res_load;
        logic                res_data;
        logic [STATUS_W-1:0] res_status;
        logic                out_load;
    } bdd_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            empty;
        logic            full;
        logic            last;
        logic            match;
        logic            out_free;
    } bdd_stat_t;

endpackage

[sv/bounded_deque_with_delete_unit.sv]
// top level of the bounded deque with delete: controller, datapath and stream ports
//
// channel    direction  handshake                     contents
// s_axis     in         s_axis_tvalid/s_axis_tready   one operation: op, item_value
// m_axis     out        m_axis_tvalid/m_axis_tready   one result: out_value, occupancy, status
//
// push, insert on full, pop on empty and unused codes: decode, then finish
// pop with data: an extra state for the registered read of the entry store
// delete: scan up to the match, then shift the entries behind it toward the front
// reset clears pointers, occupancy, output valid and state, not the entry store;
// the unit takes transfers right after it. A finished result waits in the result
// register; the next transfer is taken in the cycle the output register takes it
module bounded_deque_with_delete_unit #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // item_value
    input  logic [2:0]  s_axis_tuser,   // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // out_value, occupancy, zero pad
    output logic [1:0]  m_axis_tuser    // status
);

    bdd_pkg::bdd_cmd_t  cmd;
    bdd_pkg::bdd_stat_t stat;

    logic [bdd_pkg::VALUE_W-1:0]  out_value;
    logic [bdd_pkg::OCC_W-1:0]    occupancy;
    logic [bdd_pkg::STATUS_W-1:0] status;

    bdd_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    bdd_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .op         (s_axis_tuser),
        .item_value (s_axis_tdata),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_value  (out_value),
        .occupancy  (occupancy),
        .status     (status)
    );

    assign m_axis_tdata = {1'b0, occupancy, out_value};
    assign m_axis_tuser = status;

endmodule

[sv/bdd_ram.sv]
// generic simple dual-port ram with registered read
module bdd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/bdd_datapath.sv]
// deque datapath: ring pointers, occupancy, entry store and result registers
module bdd_datapath #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  bdd_pkg::bdd_cmd_t                cmd,
    output bdd_pkg::bdd_stat_t               stat,
    input  logic [bdd_pkg::OP_W-1:0]         op,
    input  logic [bdd_pkg::VALUE_W-1:0]      item_value,
    input  logic                             out_ready,
    output logic                             out_valid,
    output logic [bdd_pkg::VALUE_W-1:0]      out_value,
    output logic [bdd_pkg::OCC_W-1:0]        occupancy,
    output logic [bdd_pkg::STATUS_W-1:0]     status
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    logic [AW-1:0]                   head_reg, head_next;
    logic [CW-1:0]                   count_reg, count_next;
    logic [AW-1:0]                   idx_reg, idx_next;
    logic [bdd_pkg::OP_W-1:0]        op_reg, op_next;
    logic [DATA_WIDTH-1:0]           val_reg, val_next;
    logic [bdd_pkg::VALUE_W-1:0]     res_value_reg, res_value_next;
    logic [bdd_pkg::STATUS_W-1:0]    res_status_reg, res_status_next;
    logic                            out_valid_reg, out_valid_next;
    logic [bdd_pkg::VALUE_W-1:0]     out_value_reg, out_value_next;
    logic [bdd_pkg::OCC_W-1:0]       occ_reg, occ_next;
    logic [bdd_pkg::STATUS_W-1:0]    out_status_reg, out_status_next;

    logic [AW-1:0]         head_prev;
    logic [AW-1:0]         head_succ;
    logic [SW-1:0]         rd_pos;
    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic [DATA_WIDTH-1:0] rd_data;

    // ring slot of a position counted from the front
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                              input logic [SW-1:0] pos);
        logic [SW-1:0] sum;
        sum = SW'(head) + pos;
        if (sum >= SW'(DEPTH))
        begin
            sum = sum - SW'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign head_prev = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - AW'(1);
    assign head_succ = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);

    always_comb
    begin
        case (cmd.rd_sel)
            bdd_pkg::RD_BACK:  rd_pos = SW'(count_reg) - SW'(1);
            bdd_pkg::RD_FRONT: rd_pos = '0;
            bdd_pkg::RD_NEXT:  rd_pos = SW'(idx_reg) + SW'(1);
            default:           rd_pos = '0;
        endcase
        rd_addr = slot_of(head_reg, rd_pos);
    end

    always_comb
    begin
        case (cmd.wr_sel)
            bdd_pkg::WR_BACK:
            begin
                wr_addr = slot_of(head_reg, SW'(count_reg));
                wr_data = val_reg;
            end
            bdd_pkg::WR_FRONT:
            begin
                wr_addr = head_prev;
                wr_data = val_reg;
            end
            bdd_pkg::WR_SHIFT:
            begin
                wr_addr = slot_of(head_reg, SW'(idx_reg) - SW'(1));
                wr_data = rd_data;
            end
            default:
            begin
                wr_addr = head_reg;
                wr_data = val_reg;
            end
        endcase
    end

    bdd_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        head_next = head_reg;
        if (cmd.head_inc)
        begin
            head_next = head_succ;
        end
        else if (cmd.head_dec)
        begin
            head_next = head_prev;
        end

        count_next = count_reg;
        if (cmd.cnt_inc)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.cnt_dec)
        begin
            count_next = count_reg - CW'(1);
        end

        idx_next = idx_reg;
        if (cmd.idx_clear)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + AW'(1);
        end

        op_next  = cmd.in_load ? op : op_reg;
        val_next = cmd.in_load ? DATA_WIDTH'(item_value) : val_reg;

        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        if (cmd.res_load)
        begin
            // removed word sign-extended from the store width
            res_value_next  = cmd.res_data ? bdd_pkg::VALUE_W'($signed(rd_data)) : '0;
            res_status_next = cmd.res_status;
        end

        out_value_next  = out_value_reg;
        occ_next        = occ_reg;
        out_status_next = out_status_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        if (cmd.out_load)
        begin
            out_valid_next  = 1'b1;
            out_value_next  = res_value_reg;
            occ_next        = bdd_pkg::OCC_W'(count_reg);
            out_status_next = res_status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        val_reg        <= val_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        out_value_reg  <= out_value_next;
        occ_reg        <= occ_next;
        out_status_reg <= out_status_next;
    end

    assign stat.op       = op_reg;
    assign stat.empty    = (count_reg == '0);
    assign stat.full     = (count_reg == CW'(DEPTH));
    assign stat.last     = (CW'(idx_reg) + CW'(1)) >= count_reg;
    assign stat.match    = (rd_data == val_reg);
    assign stat.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign occupancy = occ_reg;
    assign status    = out_status_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("occupancy beyond depth");

    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= AW'(DEPTH - 1))
        else $error("head pointer out of ring");

    a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cnt_inc |-> !stat.full)
        else $error("insert into full store");

    a_remove_held: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cnt_dec |-> !stat.empty)
        else $error("removal from empty store");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> stat.out_free)
        else $error("result overwrites one not yet taken");

endmodule

[sv/bdd_ctrl.sv]
// deque controller state machine: sequences each operation over the datapath
module bdd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_valid,
    output logic               s_ready,
    input  bdd_pkg::bdd_stat_t stat,
    output bdd_pkg::bdd_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_DECODE  = 3'd1;
    localparam logic [2:0] S_POPDATA = 3'd2;
    localparam logic [2:0] S_SCAN    = 3'd3;
    localparam logic [2:0] S_SHIFT   = 3'd4;
    localparam logic [2:0] S_FINISH  = 3'd5;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        s_ready    = 1'b0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                s_ready     = 1'b1;
                cmd.in_load = s_valid;
                if (s_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.res_load   = 1'b1;
                cmd.res_status = bdd_pkg::ST_OK;
                state_next     = S_FINISH;
                case (stat.op)
                    bdd_pkg::OP_PUSH_BACK:
                    begin
                        if (stat.full)
                        begin
                            cmd.res_status = bdd_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.wr_en   = 1'b1;
                            cmd.wr_sel  = bdd_pkg::WR_BACK;
                            cmd.cnt_inc = 1'b1;
                        end
                    end
                    bdd_pkg::OP_PUSH_FRONT:
                    begin
                        if (stat.full)
                        begin
                            cmd.res_status = bdd_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.wr_en    = 1'b1;
                            cmd.wr_sel   = bdd_pkg::WR_FRONT;
                            cmd.head_dec = 1'b1;
                            cmd.cnt_inc  = 1'b1;
                        end
                    end
                    bdd_pkg::OP_POP_BACK:
                    begin
                        if (stat.empty)
                        begin
                            cmd.res_status = bdd_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            cmd.res_load = 1'b0;
                            cmd.rd_sel   = bdd_pkg::RD_BACK;
                            cmd.cnt_dec  = 1'b1;
                            state_next   = S_POPDATA;
                        end
                    end
                    bdd_pkg::OP_POP_FRONT:
                    begin
                        if (stat.empty)
                        begin
                            cmd.res_status = bdd_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            cmd.res_load = 1'b0;
                            cmd.rd_sel   = bdd_pkg::RD_FRONT;
                            cmd.head_inc = 1'b1;
                            cmd.cnt_dec  = 1'b1;
                            state_next   = S_POPDATA;
                        end
                    end
                    bdd_pkg::OP_DELETE:
                    begin
                        if (stat.empty)
                        begin
                            cmd.res_status = bdd_pkg::ST_NOTFOUND;
                        end
                        else
                        begin
                            cmd.res_load  = 1'b0;
                            cmd.rd_sel    = bdd_pkg::RD_FRONT;
                            cmd.idx_clear = 1'b1;
                            state_next    = S_SCAN;
                        end
                    end
                    default:
                    begin
                        cmd.res_status = bdd_pkg::ST_OK;
                    end
                endcase
            end
            S_POPDATA:
            begin
                cmd.res_load   = 1'b1;
                cmd.res_data   = 1'b1;
                cmd.res_status = bdd_pkg::ST_OK;
                state_next     = S_FINISH;
            end
            S_SCAN:
            begin
                // compare the entry at the index, fetch the one after it
                cmd.rd_sel = bdd_pkg::RD_NEXT;
                if (stat.match && stat.last)
                begin
                    cmd.cnt_dec    = 1'b1;
                    cmd.res_load   = 1'b1;
                    cmd.res_status = bdd_pkg::ST_OK;
                    state_next     = S_FINISH;
                end
                else if (stat.match)
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_SHIFT;
                end
                else if (stat.last)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = bdd_pkg::ST_NOTFOUND;
                    state_next     = S_FINISH;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_SHIFT:
            begin
                // move the entry at the index one place toward the front
                cmd.rd_sel = bdd_pkg::RD_NEXT;
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = bdd_pkg::WR_SHIFT;
                if (stat.last)
                begin
                    cmd.cnt_dec    = 1'b1;
                    cmd.res_load   = 1'b1;
                    cmd.res_status = bdd_pkg::ST_OK;
                    state_next     = S_FINISH;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_FINISH:
            begin
                s_ready      = stat.out_free;
                cmd.out_load = stat.out_free;
                cmd.in_load  = s_valid && stat.out_free;
                if (stat.out_free)
                begin
                    state_next = s_valid ? S_DECODE : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[tb/sv/testbench.sv]
// stream testbench for the bounded deque with delete, checked against a queue-based predictor
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUEUE_DEPTH      = 64;
    localparam int N_DIRECTED       = 20;
    localparam int RANDOM_OPS       = 1950;
    localparam int LONG_HOLD_AT     = N_DIRECTED + 300;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES     = 150;
    localparam int IDLE_LIMIT       = 3000;
    localparam int REPORT_LINES_MAX = 100;

    localparam logic [bdd_pkg::OP_W-1:0] OP_RSVD5 = 3'd5;
    localparam logic [bdd_pkg::OP_W-1:0] OP_RSVD6 = 3'd6;
    localparam logic [bdd_pkg::OP_W-1:0] OP_RSVD7 = 3'd7;

    typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

    typedef struct packed {
        logic [bdd_pkg::VALUE_W-1:0]  out_value;
        logic [bdd_pkg::OCC_W-1:0]    occupancy;
        logic [bdd_pkg::STATUS_W-1:0] status;
    } deque_result_t;

    typedef struct {
        logic [bdd_pkg::OP_W-1:0]    op;
        logic [bdd_pkg::VALUE_W-1:0] value;
        bit                          pinned;
        deque_result_t               result;
    } step_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    logic [bdd_pkg::VALUE_W-1:0] shadow_entries[$];
    deque_result_t               awaited_results[$];
    deque_result_t               oldest_result;
    int                          fail_count = 0;
    int                          ops_accepted = 0;
    int                          idle_cycles = 0;
    int                          burst_left = 1;

    // pinned rows carry results readable at a glance, the rest go through the predictor
    step_row_t directed_steps [N_DIRECTED] = '{
        '{bdd_pkg::OP_POP_BACK,   32'h0000_0000, 1'b1,
          '{32'h0000_0000, 7'd0, bdd_pkg::ST_EMPTY}},
        '{bdd_pkg::OP_POP_FRONT,  32'hffff_ffff, 1'b1,
          '{32'h0000_0000, 7'd0, bdd_pkg::ST_EMPTY}},
        '{bdd_pkg::OP_DELETE,     32'h0000_0000, 1'b1,
          '{32'h0000_0000, 7'd0, bdd_pkg::ST_NOTFOUND}},
        '{OP_RSVD5,               32'hffff_ffff, 1'b1,
          '{32'h0000_0000, 7'd0, bdd_pkg::ST_OK}},
        '{bdd_pkg::OP_PUSH_BACK,  32'h7fff_ffff, 1'b1,
          '{32'h0000_0000, 7'd1, bdd_pkg::ST_OK}},
        '{bdd_pkg::OP_PUSH_FRONT, 32'h8000_0000, 1'b1,
          '{32'h0000_0000, 7'd2, bdd_pkg::ST_OK}},
        '{bdd_pkg::OP_PUSH_BACK,  32'h0000_0000, 1'b1,
          '{32'h0000_0000, 7'd3, bdd_pkg::ST_OK}},
        '{bdd_pkg::OP_PUSH_BACK,  32'hffff_ffff, 1'b1,
          '{32'h0000_0000, 7'd4, bdd_pkg::ST_OK}},
        '{bdd_pkg::OP_PUSH_FRONT, 32'h0000_0000, 1'b1,
          '{32'h0000_0000, 7'd5, bdd_pkg::ST_OK}},
        '{bdd_pkg::OP_DELETE,     32'h0000_0000, 1'b1,
          '{32'h0000_0000, 7'd4, bdd_pkg::ST_OK}},
        '{bdd_pkg::OP_DELETE,     32'h1234_5678, 1'b1,
          '{32'h0000_0000, 7'd4, bdd_pkg::ST_NOTFOUND}},
        '{OP_RSVD6,               32'h0000_0000, 1'b1,
          '{32'h0000_0000, 7'd4, bdd_pkg::ST_OK}},
        '{OP_RSVD7,               32'haaaa_aaaa, 1'b1,
          '{32'h0000_0000, 7'd4, bdd_pkg::ST_OK}},
        '{bdd_pkg::OP_POP_FRONT,  32'h0000_0000, 1'b1,
          '{32'h8000_0000, 7'd3, bdd_pkg::ST_OK}},
        '{bdd_pkg::OP_POP_BACK,   32'h5555_5555, 1'b1,
          '{32'hffff_ffff, 7'd2, bdd_pkg::ST_OK}},
        '{bdd_pkg::OP_DELETE,     32'h7fff_ffff, 1'b0,
          '{32'h0000_0000, 7'd0, bdd_pkg::ST_OK}},
        '{bdd_pkg::OP_PUSH_FRONT, 32'h5555_5555, 1'b0,
          '{32'h0000_0000, 7'd0, bdd_pkg::ST_OK}},
        '{bdd_pkg::OP_POP_BACK,   32'h0000_0000, 1'b0,
          '{32'h0000_0000, 7'd0, bdd_pkg::ST_OK}},
        '{bdd_pkg::OP_POP_FRONT,  32'h0000_0000, 1'b0,
          '{32'h0000_0000, 7'd0, bdd_pkg::ST_OK}},
        '{bdd_pkg::OP_DELETE,     32'h0000_0000, 1'b1,
          '{32'h0000_0000, 7'd0, bdd_pkg::ST_NOTFOUND}}
    };

    bounded_deque_with_delete_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic deque_result_t apply_deque_op(
        input logic [bdd_pkg::OP_W-1:0]    op,
        input logic [bdd_pkg::VALUE_W-1:0] value);
        deque_result_t r;
        int            hit;
        int            i;
        r.out_value = '0;
        r.status    = bdd_pkg::ST_OK;
        hit         = -1;
        case (op)
            bdd_pkg::OP_PUSH_BACK:
                if (shadow_entries.size() >= QUEUE_DEPTH) r.status = bdd_pkg::ST_FULL;
                else shadow_entries.push_back(value);
            bdd_pkg::OP_POP_BACK:
                if (shadow_entries.size() == 0) r.status = bdd_pkg::ST_EMPTY;
                else r.out_value = shadow_entries.pop_back();
            bdd_pkg::OP_PUSH_FRONT:
                if (shadow_entries.size() >= QUEUE_DEPTH) r.status = bdd_pkg::ST_FULL;
                else shadow_entries.push_front(value);
            bdd_pkg::OP_POP_FRONT:
                if (shadow_entries.size() == 0) r.status = bdd_pkg::ST_EMPTY;
                else r.out_value = shadow_entries.pop_front();
            bdd_pkg::OP_DELETE:
            begin
                for (i = 0; i < shadow_entries.size() && hit < 0; i++)
                    if (shadow_entries[i] == value) hit = i;
                if (hit < 0) r.status = bdd_pkg::ST_NOTFOUND;
                else shadow_entries.delete(hit);
            end
            default:
                ;
        endcase
        r.occupancy = bdd_pkg::OCC_W'(shadow_entries.size());
        return r;
    endfunction

    function automatic logic [bdd_pkg::VALUE_W-1:0] fresh_value();
        logic [bdd_pkg::VALUE_W-1:0] v;
        case ($urandom_range(0, 9))
            0:
                case ($urandom_range(0, 4))
                    0: v = 32'h7fff_ffff;
                    1: v = 32'h8000_0000;
                    2: v = 32'hffff_ffff;
                    3: v = 32'h0000_0001;
                    default: v = '0;
                endcase
            1, 2, 3: v = bdd_pkg::VALUE_W'($urandom_range(0, 7));
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic logic [bdd_pkg::OP_W-1:0] pick_op(input mix_t mix);
        int roll;
        int push_top;
        int pop_top;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:  begin push_top = 80; pop_top = 92; end
            MIX_DRAIN: begin push_top = 15; pop_top = 85; end
            default:   begin push_top = 37; pop_top = 67; end
        endcase
        if (roll < 2)
        begin
            case ($urandom_range(0, 2))
                0: return OP_RSVD5;
                1: return OP_RSVD6;
                default: return OP_RSVD7;
            endcase
        end
        if (roll < push_top)
            return $urandom_range(0, 1) ? bdd_pkg::OP_PUSH_BACK : bdd_pkg::OP_PUSH_FRONT;
        if (roll < pop_top)
            return $urandom_range(0, 1) ? bdd_pkg::OP_POP_BACK : bdd_pkg::OP_POP_FRONT;
        return bdd_pkg::OP_DELETE;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        if (fail_count < REPORT_LINES_MAX)
            $display("%0t mismatch on %s: expected %0h got %0h", $realtime, what, want, got);
        fail_count++;
    endtask

    // offer one operation, hold it until the transfer, then pace the burst
    task automatic offer_op(input logic [bdd_pkg::OP_W-1:0] op,
                            input logic [bdd_pkg::VALUE_W-1:0] value,
                            input bit pinned, input deque_result_t pinned_result);
        deque_result_t predicted;
        int            gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= value;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        predicted = apply_deque_op(op, value);
        awaited_results.push_back(pinned ? pinned_result : predicted);
        ops_accepted++;
        burst_left--;
        if (burst_left <= 0)
        begin
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (awaited_results.size() == 0)
                report_mismatch("result with nothing expected", '0, m_axis_tdata[31:0]);
            else
            begin
                oldest_result = awaited_results.pop_front();
                if (m_axis_tdata[31:0] !== oldest_result.out_value)
                    report_mismatch("out_value", oldest_result.out_value, m_axis_tdata[31:0]);
                if (m_axis_tdata[38:32] !== oldest_result.occupancy)
                    report_mismatch("occupancy", 32'(oldest_result.occupancy),
                                    32'(m_axis_tdata[38:32]));
                if (m_axis_tuser !== oldest_result.status)
                    report_mismatch("status", 32'(oldest_result.status), 32'(m_axis_tuser));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // receiver: changing stall patterns, plus one long hold-off so the unit backs up
    initial
    begin : receiver
        int mix;
        int span;
        int stall_ctr;
        bit held;
        stall_ctr = 0;
        held      = 1'b0;
        forever
        begin
            mix  = $urandom_range(0, 3);
            span = $urandom_range(50, 300);
            repeat (span)
            begin
                @(posedge clk);
                if (!held && ops_accepted >= LONG_HOLD_AT)
                begin
                    held = 1'b1;
                    m_axis_tready <= 1'b0;
                    repeat (LONG_HOLD_CYCLES) @(posedge clk);
                end
                stall_ctr++;
                case (mix)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= ($urandom_range(0, 9) < 7);
                    2: m_axis_tready <= (stall_ctr % 4 == 0);
                    default: m_axis_tready <= ($urandom_range(0, 9) < 3);
                endcase
            end
        end
    end

    initial
    begin : stimulus
        int                          idx;
        int                          span;
        int                          random_sent;
        mix_t                        mix;
        logic [bdd_pkg::OP_W-1:0]    op;
        logic [bdd_pkg::VALUE_W-1:0] value;
        random_sent = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (idx = 0; idx < N_DIRECTED; idx++)
            offer_op(directed_steps[idx].op, directed_steps[idx].value,
                     directed_steps[idx].pinned, directed_steps[idx].result);

        while (random_sent < RANDOM_OPS)
        begin
            mix  = mix_t'($urandom_range(0, 2));
            span = $urandom_range(40, 160);
            if (span > RANDOM_OPS - random_sent)
                span = RANDOM_OPS - random_sent;
            repeat (span)
            begin
                op = pick_op(mix);
                if (op == bdd_pkg::OP_PUSH_BACK || op == bdd_pkg::OP_PUSH_FRONT)
                    value = fresh_value();
                else if (op == bdd_pkg::OP_DELETE && shadow_entries.size() > 0
                         && $urandom_range(0, 3) != 0)
                    value = shadow_entries[$urandom_range(0, shadow_entries.size() - 1)];
                else if (op == bdd_pkg::OP_DELETE)
                    value = fresh_value();
                else
                    value = $urandom;
                offer_op(op, value, 1'b0, '0);
                random_sent++;
            end
        end
        s_axis_tvalid <= 1'b0;

        while (awaited_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

[files.f]
sv/bdd_pkg.sv
sv/bdd_ram.sv
sv/bdd_datapath.sv
sv/bdd_ctrl.sv
sv/bounded_deque_with_delete_unit.sv
tb/sv/testbench.sv
